>>> rtl/kexp_pkg.sv
package kexp_pkg;

  // round key geometry
  localparam int unsigned Rounds   = 10;
  localparam int unsigned NumWords = 4;
  localparam logic [3:0]  RoundFirst = 4'd1;
  localparam logic [3:0]  RoundLast  = 4'(Rounds);
  localparam logic [1:0]  WordLast   = 2'(NumWords - 1);

  // field constants
  localparam logic [7:0] PolyLow     = 8'h1B;
  localparam logic [7:0] AffineConst = 8'h63;
  localparam logic [7:0] InvExp      = 8'd254;

  typedef logic [255:0][7:0] subst_tab_t;

  // word memory port
  typedef struct packed {
    logic        we;
    logic [1:0]  waddr;
    logic [31:0] wdata;
    logic [1:0]  raddr;
  } mem_req_t;

  // gf(2^8) multiply modulo x^8+x^4+x^3+x+1
  function automatic logic [7:0] gf_mul_f(logic [7:0] a, logic [7:0] b);
    logic [7:0] acc;
    logic [7:0] x;
    acc = 8'h00;
    x   = a;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) acc = acc ^ x;
      x = x[7] ? ({x[6:0], 1'b0} ^ PolyLow) : {x[6:0], 1'b0};
    end
    return acc;
  endfunction

  // byte substitution table, built at elaboration
  function automatic subst_tab_t build_subst_f();
    subst_tab_t tab;
    logic [7:0] p;
    logic [7:0] r;
    logic [7:0] inv;
    for (int i = 0; i < 256; i++) begin
      p = i[7:0];
      r = 8'h01;
      // square and multiply for x^254, zero maps to zero
      for (int b = 0; b < 8; b++) begin
        if (InvExp[b]) r = gf_mul_f(r, p);
        p = gf_mul_f(p, p);
      end
      inv = r;
      tab[i[7:0]] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                    {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AffineConst;
    end
    return tab;
  endfunction

  localparam subst_tab_t SubstTab = build_subst_f();

  // round constant for rounds one to ten
  function automatic logic [7:0] rcon_f(logic [3:0] rnd);
    logic [7:0] rc;
    case (rnd)
      4'd1:    rc = 8'h01;
      4'd2:    rc = 8'h02;
      4'd3:    rc = 8'h04;
      4'd4:    rc = 8'h08;
      4'd5:    rc = 8'h10;
      4'd6:    rc = 8'h20;
      4'd7:    rc = 8'h40;
      4'd8:    rc = 8'h80;
      4'd9:    rc = 8'h1B;
      4'd10:   rc = 8'h36;
      default: rc = 8'h00;
    endcase
    return rc;
  endfunction

endpackage

>>> rtl/aes128_key_expansion.sv
// aes-128 key expansion
//
// input channel: in_valid_i / in_stall_o carry one 128-bit cipher key as
// key_high_i (key bytes 0..7) and key_low_i (key bytes 8..15). a request is
// taken when in_valid_i is high and in_stall_o is low.
// output channel: out_valid_o / out_stall_i carry 40 round key words per
// key, round 1 word 0 first, with round_number_o, word_index_o and
// final_word_o (high on word 3 of round 10).
// a taken request passes through the holding and current key registers
// before reaching the output. throughput: one word per cycle while not
// stalled; the word generator produces one word a cycle while not stalled,
// reading the previous round's matching word from a four-entry word memory.
// a one-key holding register takes the next request while the current key
// is still expanding, so keys follow each other with no gap on the output.
// when out_stall_i is high the output register holds its word and the
// generator waits; in_stall_o rises once the holding register is full.
// reset clears all control state; the block is idle with nothing pending.
module aes128_key_expansion
  import kexp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [63:0] key_high_i,
  input  logic [63:0] key_low_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  round_number_o,
  output logic [1:0]  word_index_o,
  output logic [31:0] key_word_o,
  output logic        final_word_o
);

  logic         pend_valid_q;
  logic [127:0] pend_q;
  logic [127:0] key_cur_q;
  logic         active_q;
  logic [3:0]   rnd_q;
  logic [1:0]   idx_q;
  logic [31:0]  prev_q;
  logic         out_valid_q;
  logic [3:0]   out_rnd_q;
  logic [1:0]   out_idx_q;
  logic [31:0]  out_word_q;
  logic         out_final_q;

  logic         accept;
  logic         advance;
  logic         last_word;
  logic         start;
  logic [31:0]  key_word;
  logic [31:0]  old_word;
  logic [31:0]  sub_src;
  logic [31:0]  t_word;
  logic [31:0]  new_word;
  logic [31:0]  rdata;
  mem_req_t     mem_req;

  // handshake and sequencing
  assign accept    = in_valid_i && !pend_valid_q;
  assign advance   = active_q && (!out_valid_q || !out_stall_i);
  assign last_word = (rnd_q == RoundLast) && (idx_q == WordLast);
  assign start     = pend_valid_q && (!active_q || (advance && last_word));

  // holding register for the next key
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (accept) begin
      pend_valid_q <= 1'b1;
    end else if (start) begin
      pend_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) pend_q <= {key_high_i, key_low_i};
  end

  // cipher key word for the current index
  always_comb begin
    case (idx_q)
      2'd0:    key_word = key_cur_q[127:96];
      2'd1:    key_word = key_cur_q[95:64];
      2'd2:    key_word = key_cur_q[63:32];
      default: key_word = key_cur_q[31:0];
    endcase
  end

  // previous round word: cipher key in round one, memory afterwards
  assign old_word = (rnd_q == RoundFirst) ? key_word : rdata;
  assign sub_src  = ((rnd_q == RoundFirst) && (idx_q == 2'd0)) ? key_cur_q[31:0] : prev_q;

  kexp_subword u_subword (
    .word_i (sub_src),
    .rnd_i  (rnd_q),
    .t_o    (t_word)
  );

  assign new_word = old_word ^ ((idx_q == 2'd0) ? t_word : prev_q);

  // write back the new word, read ahead for the next one
  always_comb begin
    mem_req.we    = advance;
    mem_req.waddr = idx_q;
    mem_req.wdata = new_word;
    mem_req.raddr = advance ? idx_q + 2'd1 : idx_q;
  end

  kexp_word_mem u_word_mem (
    .clk_i   (clk_i),
    .req_i   (mem_req),
    .rdata_o (rdata)
  );

  // round and word counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      rnd_q    <= RoundFirst;
      idx_q    <= 2'd0;
    end else if (start) begin
      active_q <= 1'b1;
      rnd_q    <= RoundFirst;
      idx_q    <= 2'd0;
    end else if (advance) begin
      idx_q <= idx_q + 2'd1;
      if (idx_q == WordLast) rnd_q <= rnd_q + 4'd1;
      if (last_word) active_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start) key_cur_q <= pend_q;
    if (advance) prev_q <= new_word;
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_rnd_q   <= rnd_q;
      out_idx_q   <= idx_q;
      out_word_q  <= new_word;
      out_final_q <= last_word;
    end
  end

  assign in_stall_o     = pend_valid_q;
  assign out_valid_o    = out_valid_q;
  assign round_number_o = out_rnd_q;
  assign word_index_o   = out_idx_q;
  assign key_word_o     = out_word_q;
  assign final_word_o   = out_final_q;

endmodule

>>> rtl/kexp_word_mem.sv
module kexp_word_mem
  import kexp_pkg::*;
(
  input  logic        clk_i,
  input  mem_req_t    req_i,
  output logic [31:0] rdata_o
);

  logic [31:0] mem_q [NumWords];
  logic [31:0] rdata_q;

  // one write port
  always_ff @(posedge clk_i) begin
    if (req_i.we) mem_q[req_i.waddr] <= req_i.wdata;
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[req_i.raddr];
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/kexp_subword.sv
module kexp_subword
  import kexp_pkg::*;
(
  input  logic [31:0] word_i,
  input  logic [3:0]  rnd_i,
  output logic [31:0] t_o
);

  logic [31:0] rot;
  logic [31:0] sub;

  // rotate by one byte, substitute each byte
  always_comb begin
    rot = {word_i[23:0], word_i[31:24]};
    for (int i = 0; i < 4; i++) begin
      sub[8*i +: 8] = SubstTab[rot[8*i +: 8]];
    end
  end

  // round constant into the top byte
  assign t_o = sub ^ {rcon_f(rnd_i), 24'h000000};

endmodule

>>> rtl/kexp_checker.sv
module kexp_checker
  import kexp_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic [63:0] key_high_i,
  input logic [63:0] key_low_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [3:0]  round_number_o,
  input logic [1:0]  word_index_o,
  input logic [31:0] key_word_o,
  input logic        final_word_o
);

  // final flag only on the last word of the last round
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && final_word_o |-> round_number_o == RoundLast && word_index_o == WordLast)
    else $error("final word flag on a word other than the last");

  // round number stays within the schedule
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> round_number_o >= RoundFirst && round_number_o <= RoundLast)
    else $error("round number out of range");

  // words of one key leave back to back in index order
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !final_word_o |=>
      out_valid_o && word_index_o == $past(word_index_o) + 2'd1)
    else $error("gap or misordered word within a key");

  // stalled output holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(key_word_o) && $stable(round_number_o) &&
      $stable(word_index_o) && $stable(final_word_o))
    else $error("output changed while stalled");

  // stalled request holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=>
      in_valid_i && $stable(key_high_i) && $stable(key_low_i))
    else $error("request changed while stalled");

endmodule

bind aes128_key_expansion kexp_checker u_kexp_checker (.*);

>>> test/tb_aes128_key_expansion.sv
`timescale 1ns / 1ps

module tb_aes128_key_expansion
  import kexp_pkg::*;
();

  localparam logic [7:0]  FieldPolyLow = 8'h1B;
  localparam logic [7:0]  AffineAdd    = 8'h63;
  localparam logic [7:0]  RconFirst    = 8'h01;
  localparam int unsigned NumPresets   = 13;
  localparam int unsigned RandomKeys   = 487;
  localparam int unsigned HoldOffCycles = 300;
  localparam int unsigned EndTail      = 20;
  localparam int unsigned WatchLimit   = 3000;
  localparam int unsigned MaxReports   = 10;

  typedef enum int unsigned {
    StallNone,
    StallLight,
    StallHeavy,
    StallLong
  } stall_mode_e;

  typedef struct packed {
    logic [3:0]  rnd;
    logic [1:0]  idx;
    logic [31:0] word;
    logic        fin;
  } key_word_t;

  // expands each taken key into its round key words and matches the output
  class round_key_board;
    logic [7:0]  subst_lut [256];
    key_word_t   expected_words [$];
    int unsigned mismatches;

    function new();
      logic [7:0] p;
      logic [7:0] inv;
      for (int v = 0; v < 256; v++) begin
        p   = v[7:0];
        inv = 8'h01;
        // x^254 as the product of x^2, x^4 ... x^128, zero stays zero
        for (int k = 1; k < 8; k++) begin
          p   = gf_times(p, p);
          inv = gf_times(inv, p);
        end
        subst_lut[v[7:0]] = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^
                            {inv[4:0], inv[7:5]} ^ {inv[3:0], inv[7:4]} ^ AffineAdd;
      end
      mismatches = 0;
    endfunction

    function logic [7:0] xtime(logic [7:0] a);
      return {a[6:0], 1'b0} ^ (a[7] ? FieldPolyLow : 8'h00);
    endfunction

    // horner form, top bit of b first
    function logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
      logic [7:0] acc;
      acc = 8'h00;
      for (int i = 7; i >= 0; i--) begin
        acc = xtime(acc) ^ (b[i] ? a : 8'h00);
      end
      return acc;
    endfunction

    function void note_key(logic [63:0] hi, logic [63:0] lo);
      logic [31:0] w [4];
      logic [31:0] rot;
      logic [31:0] t;
      logic [7:0]  rc;
      key_word_t   e;
      w[0] = hi[63:32];
      w[1] = hi[31:0];
      w[2] = lo[63:32];
      w[3] = lo[31:0];
      rc   = RconFirst;
      for (int r = 1; r <= Rounds; r++) begin
        // rotate by one byte, substitute, fold in the round constant
        rot = {w[3][23:0], w[3][31:24]};
        t = {subst_lut[rot[31:24]] ^ rc, subst_lut[rot[23:16]],
             subst_lut[rot[15:8]], subst_lut[rot[7:0]]};
        w[0] = w[0] ^ t;
        w[1] = w[1] ^ w[0];
        w[2] = w[2] ^ w[1];
        w[3] = w[3] ^ w[2];
        for (int j = 0; j < NumWords; j++) begin
          e.rnd  = 4'(r);
          e.idx  = 2'(j);
          e.word = w[j[1:0]];
          e.fin  = (e.rnd == RoundLast) && (e.idx == WordLast);
          expected_words = {expected_words, e};
        end
        rc = xtime(rc);
      end
    endfunction

    function void check_word(logic [3:0] rn, logic [1:0] wi, logic [31:0] kw, logic fw);
      key_word_t e;
      if (expected_words.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("unexpected word: round %0d word %0d key %h final %b", rn, wi, kw, fw);
        return;
      end
      e = expected_words.pop_front();
      if (rn !== e.rnd || wi !== e.idx || kw !== e.word || fw !== e.fin) begin
        mismatches++;
        if (mismatches <= MaxReports) begin
          $display("mismatch: expected round %0d word %0d key %h final %b",
                   e.rnd, e.idx, e.word, e.fin);
          $display("          actual   round %0d word %0d key %h final %b",
                   rn, wi, kw, fw);
        end
      end
    endfunction
  endclass

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [63:0] key_high_i  = '0;
  logic [63:0] key_low_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [3:0]  round_number_o;
  logic [1:0]  word_index_o;
  logic [31:0] key_word_o;
  logic        final_word_o;

  round_key_board board;
  int unsigned    keys_taken = 0;
  int unsigned    idle_cycles = 0;

  aes128_key_expansion dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .key_high_i     (key_high_i),
    .key_low_i      (key_low_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .round_number_o (round_number_o),
    .word_index_o   (word_index_o),
    .key_word_o     (key_word_o),
    .final_word_o   (final_word_o)
  );

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // gap before the next request, mostly short with a few long ones
  function automatic int unsigned idle_gap(bit burst);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (burst || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 4);
    return $urandom_range(20, 100);
  endfunction

  // offer one key request and hold it until taken
  task automatic offer_key(input logic [127:0] k, input int unsigned gap);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    key_high_i <= k[127:64];
    key_low_i  <= k[63:0];
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    board.note_key(k[127:64], k[63:0]);
    keys_taken++;
  endtask

  // output monitor
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i)
      board.check_word(round_number_o, word_index_o, key_word_o, final_word_o);
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= WatchLimit) begin
      $display("status: fail");
      $finish;
    end
  end

  // receiver stalls, one long hold-off so the block backs up into its input
  initial begin : receiver
    stall_mode_e mode;
    int unsigned span;
    bit          held;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!held && keys_taken >= 20) begin
        held = 1'b1;
        out_stall_i <= 1'b1;
        repeat (HoldOffCycles) @(posedge clk_i);
      end else begin
        mode = stall_mode_e'($urandom_range(0, 3));
        span = $urandom_range(20, 200);
        repeat (span) begin
          if (mode == StallLong && $urandom_range(0, 29) == 0) begin
            out_stall_i <= 1'b1;
            repeat ($urandom_range(20, 80)) @(posedge clk_i);
          end else begin
            case (mode)
              StallLight, StallLong: out_stall_i <= ($urandom_range(0, 3) == 0);
              StallHeavy:            out_stall_i <= 1'($urandom_range(0, 1));
              default:               out_stall_i <= 1'b0;
            endcase
            @(posedge clk_i);
          end
        end
      end
    end
  end

  // reset, directed keys, random keys, drain
  initial begin : stimulus
    logic [127:0] k;
    board = new();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed keys: extremes, the standard test key, zero bytes in the last word
    for (int i = 0; i < NumPresets; i++) begin
      case (i)
        0:       k = '0;
        1:       k = '1;
        2:       k = 128'h2b7e151628aed2a6abf7158809cf4f3c;
        3:       k = 128'h000102030405060708090a0b0c0d0e0f;
        4:       k = {16{8'h55}};
        5:       k = {16{8'haa}};
        6:       k = 128'h80000000000000000000000000000001;
        7:       k = {16{8'h01}};
        8:       k = 128'hffffffffffffffffffffffff00000000;
        9:       k = 128'h00000000000000000000000000000080;
        10:      k = 128'h000000000000000000000000ffffffff;
        11:      k = 128'h0123456789abcdeffedcba9876543210;
        default: k = {16{8'h63}};
      endcase
      offer_key(k, idle_gap(i < 6));
    end

    // random keys, a quarter of them with many zero bytes
    for (int i = 0; i < RandomKeys; i++) begin
      k = {$urandom(), $urandom(), $urandom(), $urandom()};
      if ($urandom_range(0, 3) == 0) begin
        for (int b = 0; b < 16; b++)
          if ($urandom_range(0, 1) == 0) k[8*b +: 8] = 8'h00;
      end
      offer_key(k, idle_gap(((i / 60) % 3) == 0));
    end
    in_valid_i <= 1'b0;

    while (board.expected_words.size() != 0) @(posedge clk_i);
    repeat (EndTail) @(posedge clk_i);
    if (board.mismatches == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

>>> aes128_key_expansion.f
rtl/kexp_pkg.sv
rtl/kexp_word_mem.sv
rtl/kexp_subword.sv
rtl/aes128_key_expansion.sv
rtl/kexp_checker.sv
test/tb_aes128_key_expansion.sv
